// File: hdl/glyph_cell_cache_fifo_macros.svh
// ----------------------------------------------------------------------------
// glyph cell cache assertion macros
// implication helpers clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef GLYPH_CELL_CACHE_FIFO_MACROS_SVH
`define GLYPH_CELL_CACHE_FIFO_MACROS_SVH

// same-cycle implication
`define GCCF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glyph cell cache: same-cycle check failed");

// next-cycle implication
`define GCCF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glyph cell cache: next-cycle check failed");

`endif

// File: hdl/gccf_pkg.sv
// ----------------------------------------------------------------------------
// gccf_pkg
// shared types, register indexes and helpers of the glyph cell cache
// ----------------------------------------------------------------------------
package gccf_pkg;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 9;
  localparam int PROD_W = 2 * CFG_DW;

  localparam logic [CFG_IW-1:0] REG_CELL_COLS = 2'd0;
  localparam logic [CFG_IW-1:0] REG_CELL_ROWS = 2'd1;

  localparam logic [CFG_DW-1:0] CELL_COLS_RST = 9'd16;
  localparam logic [CFG_DW-1:0] CELL_ROWS_RST = 9'd16;
  localparam logic [CFG_DW-1:0] CELL_DIM_MAX  = 9'd256;

  typedef struct packed {
    logic [15:0] char_code;
  } gccf_in_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
    logic        evicted;
    logic [15:0] evicted_char;
    logic        config_error;
  } gccf_out_t;

  typedef struct packed {
    logic              bad;
    logic [PROD_W-1:0] n;
  } gccf_geom_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
  } gccf_pos_t;

  // last dimension index, zero for an empty dimension
  function automatic logic [7:0] gccf_last(input logic [CFG_DW-1:0] dim);
    logic [CFG_DW-1:0] m1;
    m1 = dim - 9'd1;
    return (dim == '0) ? 8'd0 : m1[7:0];
  endfunction

  // step one cell down: column first, then row, wrapping
  function automatic gccf_pos_t gccf_step(input gccf_pos_t pos,
                                          input logic [7:0] col_last,
                                          input logic [7:0] row_last);
    gccf_pos_t res;
    res = pos;
    if (pos.col != 8'd0) begin
      res.col = pos.col - 8'd1;
    end else begin
      res.col = col_last;
      res.row = (pos.row != 8'd0) ? pos.row - 8'd1 : row_last;
    end
    return res;
  endfunction

endpackage

// File: hdl/gccf_if.sv
// ----------------------------------------------------------------------------
// gccf channel interfaces
// valid/ready channels carrying request and result words
// ----------------------------------------------------------------------------
interface gccf_in_if;
  logic               valid;
  logic               ready;
  gccf_pkg::gccf_in_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface gccf_out_if;
  logic                valid;
  logic                ready;
  gccf_pkg::gccf_out_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// File: hdl/gccf_geom.sv
// ----------------------------------------------------------------------------
// gccf_geom
// atlas cell count and geometry check against slot capacity
// ----------------------------------------------------------------------------
module gccf_geom #(
  parameter int SLOTS = 256
) (
  input  logic [gccf_pkg::CFG_DW-1:0] cols,
  input  logic [gccf_pkg::CFG_DW-1:0] rows,
  output gccf_pkg::gccf_geom_t        geom
);
  import gccf_pkg::*;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(cols) * PROD_W'(rows);

  always_comb begin
    geom.n   = prod;
    geom.bad = (cols == '0) || (rows == '0) ||
               (cols > CELL_DIM_MAX) || (rows > CELL_DIM_MAX) ||
               (prod > PROD_W'(SLOTS));
  end

endmodule

// File: hdl/glyph_cell_cache_fifo.sv
// ----------------------------------------------------------------------------
// glyph_cell_cache_fifo
// character code to atlas cell cache, fully associative, fifo replacement
//
// in_ch takes one word with a character code; out_ch returns one result word
// per request: hit flag, cell column and row, evicted flag and code, and a
// geometry error flag. cfg_we/cfg_idx/cfg_wdata write cell_cols (index 0) or
// cell_rows (index 1); each write flushes the cache. write only while idle.
// lookup walks the filled slots one per cycle through the single read port
// of the tag memory and stops at a hit; a miss walks all fill slots, fill
// being the occupied slots (at most SLOTS), then reads the victim slot
// (ST_EVRD) and writes the new tag (ST_EVWR). a bad geometry answers
// without a walk. one request at a time: in_ch.ready stays low until the
// result sits in the output register.
// a stalled out_ch holds the result; the next request may be accepted while
// it waits, but its own result waits behind it.
// reset empties the cache and loads a 16 x 16 geometry; no clearing pass.
// ----------------------------------------------------------------------------
module glyph_cell_cache_fifo #(
  parameter int SLOTS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gccf_in_if.sink                     in_ch,
  gccf_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [gccf_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [gccf_pkg::CFG_DW-1:0] cfg_wdata
);
  import gccf_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_EVRD = 3'd2;
  localparam logic [2:0] ST_EVWR = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CFG_DW-1:0] cols_r, cols_nxt;
  logic [CFG_DW-1:0] rows_r, rows_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]     next_slot_r, next_slot_nxt;
  gccf_pos_t         next_pos_r, next_pos_nxt;
  logic [15:0]       code_r, code_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     rd_k_r, rd_k_nxt;
  logic              pend_r, pend_nxt;
  gccf_pos_t         iss_pos_r, iss_pos_nxt;
  gccf_pos_t         cmp_pos_r, cmp_pos_nxt;
  gccf_out_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  gccf_out_t         out_word_r, out_word_nxt;

  logic [15:0]       tag_mem [SLOTS];
  logic [15:0]       rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic              alloc;

  gccf_geom_t        geom;
  logic [7:0]        col_last, row_last;
  logic [CFG_DW-1:0] new_cols, new_rows;
  logic [CW-1:0]     slot_inc;
  logic              full;

  gccf_geom #(.SLOTS(SLOTS)) u_geom (
    .cols (cols_r),
    .rows (rows_r),
    .geom (geom)
  );

  assign col_last = gccf_last(cols_r);
  assign row_last = gccf_last(rows_r);
  assign full     = (fill_r == n_r);
  assign slot_inc = CW'(next_slot_r) + CW'(1);
  assign alloc    = (state_r == ST_EVWR);
  assign rd_addr  = (state_r == ST_SCAN) ? rd_k_r[AW-1:0] : next_slot_r;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.word  = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    fill_nxt      = fill_r;
    next_slot_nxt = next_slot_r;
    next_pos_nxt  = next_pos_r;
    code_nxt      = code_r;
    n_nxt         = n_r;
    rd_k_nxt      = rd_k_r;
    pend_nxt      = pend_r;
    iss_pos_nxt   = iss_pos_r;
    cmp_pos_nxt   = cmp_pos_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt  = out_word_r;
    new_cols      = cols_r;
    new_rows      = rows_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          code_nxt = in_ch.word.char_code;
          res_nxt  = '0;
          if (geom.bad) begin
            res_nxt.config_error = 1'b1;
            state_nxt            = ST_DONE;
          end else begin
            n_nxt       = geom.n[CW-1:0];
            rd_k_nxt    = '0;
            pend_nxt    = 1'b0;
            iss_pos_nxt = '{col: col_last, row: row_last};
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (pend_r && (rd_data_r == code_r)) begin
          res_nxt.hit      = 1'b1;
          res_nxt.cell_col = cmp_pos_r.col;
          res_nxt.cell_row = cmp_pos_r.row;
          state_nxt        = ST_DONE;
        end else if (rd_k_r < fill_r) begin
          pend_nxt    = 1'b1;
          cmp_pos_nxt = iss_pos_r;
          iss_pos_nxt = gccf_step(iss_pos_r, col_last, row_last);
          rd_k_nxt    = rd_k_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_EVRD;
          end
        end
      end
      ST_EVRD: begin
        state_nxt = ST_EVWR;
      end
      ST_EVWR: begin
        res_nxt.evicted      = full;
        res_nxt.evicted_char = full ? rd_data_r : 16'd0;
        res_nxt.cell_col     = next_pos_r.col;
        res_nxt.cell_row     = next_pos_r.row;
        next_pos_nxt         = gccf_step(next_pos_r, col_last, row_last);
        next_slot_nxt        = (slot_inc >= n_r) ? '0 : slot_inc[AW-1:0];
        if (!full) begin
          fill_nxt = fill_r + CW'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register write flushes the cache
    if (cfg_we && ((cfg_idx == REG_CELL_COLS) || (cfg_idx == REG_CELL_ROWS))) begin
      if (cfg_idx == REG_CELL_COLS) begin
        new_cols = cfg_wdata;
      end else begin
        new_rows = cfg_wdata;
      end
      cols_nxt      = new_cols;
      rows_nxt      = new_rows;
      fill_nxt      = '0;
      next_slot_nxt = '0;
      next_pos_nxt  = '{col: gccf_last(new_cols), row: gccf_last(new_rows)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cols_r      <= CELL_COLS_RST;
      rows_r      <= CELL_ROWS_RST;
      fill_r      <= '0;
      next_slot_r <= '0;
      next_pos_r  <= '{col: gccf_last(CELL_COLS_RST), row: gccf_last(CELL_ROWS_RST)};
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      fill_r      <= fill_nxt;
      next_slot_r <= next_slot_nxt;
      next_pos_r  <= next_pos_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    n_r        <= n_nxt;
    rd_k_r     <= rd_k_nxt;
    iss_pos_r  <= iss_pos_nxt;
    cmp_pos_r  <= cmp_pos_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  // tag memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (alloc) begin
      tag_mem[next_slot_r] <= code_r;
    end
    rd_data_r <= tag_mem[rd_addr];
  end

  `include "glyph_cell_cache_fifo_macros.svh"

  `GCCF_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `GCCF_ASSERT_IMP(a_err_word_clean, out_ch.valid && out_ch.word.config_error, !out_ch.word.hit && !out_ch.word.evicted)
  `GCCF_ASSERT_IMP(a_hit_no_evict, out_ch.valid && out_ch.word.hit, !out_ch.word.evicted && (out_ch.word.evicted_char == 16'd0))
  `GCCF_ASSERT_IMP(a_fill_bounded, 1'b1, fill_r <= CW'(SLOTS))

endmodule
